FILE: design/sha256_stream_hasher_defines.svh
// Assertion macros for the hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/sha256_pkg.sv
package sha256_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data;
		logic [2:0] spare_bits;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// round unit control
	typedef struct packed {
		logic       start;
		logic       load_init;
	} rnd_ctrl_t;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARKER = 8'h80;
	localparam logic [7:0] BYTE_MASK  = 8'hFF;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

FILE: design/sha256_stream_hasher.sv
// SHA-256 stream hasher.
// Input channel (in, in_valid, in_stall): one item per accepted edge. Mode 0
// absorbs one message byte; mode 1 finishes the message (optional partial
// byte in the high bits of data, spare_bits of them) and yields eight items
// on the output channel (out, out_valid, out_stall), word 0 first, the last
// flagged by last_word.
// A byte that does not fill the block is taken with in_stall staying low. The
// 64th byte starts a compression: the buffer is packed into words, the rounds
// run in the shared round unit, the result is added into the hash and control
// is handed back, all with in_stall high. A finish packs and compresses one
// padding block, or two when 56 or more bytes are held, then emits the digest
// at one word per cycle while out_stall is low.
// in_stall is high throughout.
// While out_stall is high the current digest word is held and nothing moves.
// Reset (arst_n low) loads the initial hash words and clears the byte and bit
// counts; the buffer itself is not cleared.
module sha256_stream_hasher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::in_item_t   in,
	input  logic                   in_valid,
	output logic                   in_stall,
	output sha256_pkg::out_item_t  out,
	output logic                   out_valid,
	input  logic                   out_stall
);
	import sha256_pkg::*;
	`include "sha256_stream_hasher_defines.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COMP  = 3'd1;
	localparam logic [2:0] ST_PACK  = 3'd2;
	localparam logic [2:0] ST_PCOMP = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]  state_q;
	logic [7:0]  buf_q [64];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic [7:0]  marker_q;
	logic        two_q;
	logic        second_q;
	logic [6:0]  pos_q;
	logic [7:0]  rd_q;
	logic [31:0] wbuf_q [16];
	logic [2:0]  widx_q;
	logic        rnd_busy, rnd_done;
	logic [31:0] hash_word [8];
	rnd_ctrl_t   ctrl;
	logic        mark_fin_q;

	logic        acc;
	logic [7:0]  keep, mk;
	logic [6:0]  qpos;
	logic [6:0]  bpos;
	logic [7:0]  pbyte;
	logic [7:0]  lenb;
	logic [6:0]  pack_fill;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		keep = BYTE_MASK << (4'd8 - {1'b0, in.spare_bits});
		if (in.spare_bits == 3'd0) mk = PAD_MARKER;
		else mk = (in.data & keep) | (PAD_MARKER >> in.spare_bits);
	end

	// absorb path: full buffer, every byte comes from it
	assign pack_fill = mark_fin_q ? {1'b0, fill_q} : 7'd64;

	// padded byte at pos_q - 1 (buffer byte read last cycle in rd_q)
	always_comb begin
		qpos = pos_q - 7'd1;
		bpos = {second_q, qpos[5:0]};
		lenb = total_q[8 * (7 - int'(qpos[2:0])) +: 8];
		if (bpos < pack_fill) pbyte = rd_q;
		else if (bpos == pack_fill) pbyte = marker_q;
		else if (qpos[5:3] == 3'd7 && (second_q == two_q)) pbyte = lenb;
		else pbyte = 8'h00;
	end

	always_ff @(posedge clk) begin
		if (acc && in.mode == MODE_ABSORB) buf_q[fill_q] <= in.data;
		rd_q <= buf_q[pos_q[5:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PACK && pos_q != 7'd0 && pos_q <= 7'd64)
			wbuf_q[qpos[5:2]][8 * (3 - int'(qpos[1:0])) +: 8] <= pbyte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			total_q  <= '0;
			marker_q <= '0;
			pos_q    <= '0;
			second_q <= 1'b0;
			two_q    <= 1'b0;
			widx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (in.mode == MODE_ABSORB) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								pos_q    <= '0;
								second_q <= 1'b0;
								two_q    <= 1'b0;
								marker_q <= '0;
								total_q  <= '0;
								state_q  <= ST_PACK;
							end
						end else begin
							marker_q <= mk;
							total_q  <= bits_q + {61'd0, in.spare_bits};
							two_q    <= (fill_q >= 6'd56);
							second_q <= 1'b0;
							pos_q    <= '0;
							state_q  <= ST_PACK;
						end
					end
				end
				ST_PACK: begin
					pos_q <= pos_q + 7'd1;
					if (pos_q == 7'd65) state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (rnd_done) begin
						state_q <= ST_PCOMP;
					end
				end
				ST_PCOMP: begin
					if (!rnd_busy) begin
						if (!mark_fin_q) begin
							state_q <= ST_IDLE;
						end else if (two_q && !second_q) begin
							second_q <= 1'b1;
							pos_q    <= '0;
							state_q  <= ST_PACK;
						end else begin
							widx_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							bits_q  <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// finishing flag: set on a finish item, cleared by an absorb item and after the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mark_fin_q <= 1'b0;
		else if (acc) mark_fin_q <= (in.mode == MODE_FINISH);
		else if (state_q == ST_EMIT && !out_stall && widx_q == 3'd7) mark_fin_q <= 1'b0;
	end

	always_comb begin
		ctrl.start     = (state_q == ST_PACK) && (pos_q == 7'd65);
		ctrl.load_init = (state_q == ST_EMIT) && !out_stall && (widx_q == 3'd7);
	end

	sha256_round_unit u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.block_w   (wbuf_q),
		.busy      (rnd_busy),
		.done      (rnd_done),
		.hash_word (hash_word)
	);

	assign out_valid        = (state_q == ST_EMIT);
	assign out.digest_word  = hash_word[widx_q];
	assign out.word_index   = widx_q;
	assign out.last_word    = (widx_q == 3'd7);

	`SHA_ASSERT_IMP(a_stall_busy, state_q != ST_IDLE, in_stall, "item taken while busy")
	`SHA_ASSERT_IMP(a_last_idx, out_valid && out.last_word, widx_q == 3'd7,
		"last word flag off position")
	`SHA_ASSERT_NEXT(a_emit_hold, out_valid && out_stall, out_valid && $stable(widx_q),
		"digest word moved under stall")

endmodule

FILE: design/sha256_round_unit.sv
module sha256_round_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::rnd_ctrl_t  ctrl,
	input  logic [31:0]            block_w [16],
	output logic                   busy,
	output logic                   done,
	output logic [31:0]            hash_word [8]
);
	import sha256_pkg::*;
	`include "sha256_stream_hasher_defines.svh"

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;

	always_comb begin
		w_cur = w_q[0];
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + w_cur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
		end else begin
			done_q <= 1'b0;
			if (ctrl.load_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
			end else if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				for (int i = 0; i < 16; i++) w_q[i] <= block_w[i];
			end else if (busy_q) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				rnd_q  <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign busy = busy_q | done_q;
	assign done = done_q;
	always_comb for (int i = 0; i < 8; i++) hash_word[i] = h_q[i];

	`SHA_ASSERT_NEXT(a_done_after_last, busy_q && rnd_q == 6'd63 && !ctrl.start && !ctrl.load_init,
		done_q, "round 63 not followed by done")
	`SHA_ASSERT_IMP(a_no_start_busy, ctrl.start, !busy_q && !done_q,
		"start while compressing")
	`SHA_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held over two cycles")

endmodule

FILE: tb/sv/sha256_stream_hasher_tb.sv
module sha256_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sha256_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_item_t in = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	out_item_t out;
	logic out_valid;
	logic out_stall = 1'b0;

	sha256_stream_hasher u_top (
		.clk(clk), .arst_n(arst_n), .in(in), .in_valid(in_valid), .in_stall(in_stall),
		.out(out), .out_valid(out_valid), .out_stall(out_stall)
	);

	always #5 clk = ~clk;

	// hasher model
	logic [31:0] h_state [8];
	logic [7:0] blk_buf [64];
	int unsigned fill;
	logic [63:0] nbits;
	out_item_t digest_q [$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit hold_rx = 1'b0;

	function automatic logic [31:0] ror(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block(input logic [7:0] b [64]);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = h_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--) v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) h_state[i] += v[i];
	endtask

	task automatic hasher_reset();
		for (int i = 0; i < 8; i++) h_state[i] = INIT_H[i];
		fill = 0;
		nbits = '0;
	endtask

	task automatic predict_digest(input in_item_t it);
		logic [7:0] tail [128];
		logic [7:0] b [64];
		logic [7:0] mark, keep;
		logic [63:0] total;
		int nblk;
		out_item_t r;
		if (it.mode == MODE_ABSORB) begin
			blk_buf[fill] = it.data;
			nbits += 64'd8;
			fill++;
			if (fill == 64) begin
				compress_block(blk_buf);
				fill = 0;
			end
			return;
		end
		if (it.spare_bits == 0) mark = PAD_MARKER;
		else begin
			keep = BYTE_MASK << (8 - it.spare_bits);
			mark = (it.data & keep) | (PAD_MARKER >> it.spare_bits);
		end
		total = nbits + 64'(it.spare_bits);
		for (int i = 0; i < 128; i++) tail[i] = (i < fill) ? blk_buf[i] : 8'h00;
		tail[fill] = mark;
		nblk = (fill >= 56) ? 2 : 1;
		for (int i = 0; i < 8; i++) tail[nblk*64 - 1 - i] = total[8*i +: 8];
		for (int k = 0; k < nblk; k++) begin
			for (int i = 0; i < 64; i++) b[i] = tail[k*64 + i];
			compress_block(b);
		end
		for (int i = 0; i < 8; i++) begin
			r.digest_word = h_state[i];
			r.word_index = 3'(i);
			r.last_word = (i == 7);
			digest_q.push_back(r);
		end
		hasher_reset();
	endtask

	task automatic send_item(input logic m, input logic [7:0] d, input logic [2:0] sp);
		in_item_t it;
		it.mode = m;
		it.data = d;
		it.spare_bits = sp;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_digest(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_message(input int len, input bit rnd_fin);
		for (int i = 0; i < len; i++) send_item(MODE_ABSORB, 8'($urandom), 3'($urandom));
		if (rnd_fin) send_item(MODE_FINISH, 8'($urandom), 3'($urandom));
		else send_item(MODE_FINISH, 8'($urandom), 3'd0);
	endtask

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected word: expected none actual %h", $time, out);
				errors++;
			end else begin
				if (out.digest_word !== digest_q[0].digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time,
						digest_q[0].digest_word, out.digest_word);
					errors++;
				end
				if (out.word_index !== digest_q[0].word_index) begin
					$display("%0t: word_index expected %0d actual %0d", $time,
						digest_q[0].word_index, out.word_index);
					errors++;
				end
				if (out.last_word !== digest_q[0].last_word) begin
					$display("%0t: last_word expected %0b actual %0b", $time,
						digest_q[0].last_word, out.last_word);
					errors++;
				end
				void'(digest_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 15) - 1) @(posedge clk);
		end else out_stall <= 1'b0;
	end

	task automatic test_directed();
		send_item(MODE_FINISH, 8'h00, 3'd0);                      // empty message
		send_item(MODE_FINISH, 8'hff, 3'd7);                      // seven-bit message
		send_item(MODE_ABSORB, 8'hff, 3'd7);
		send_item(MODE_FINISH, 8'h00, 3'd1);
		send_item(MODE_ABSORB, 8'h00, 3'd0);
		send_item(MODE_FINISH, 8'hff, 3'd0);
		send_item(MODE_FINISH, 8'ha5, 3'd4);
		drain();
	endtask

	task automatic test_block_edges();
		int lens [3] = '{55, 56, 64};
		foreach (lens[i]) send_message(lens[i], i[0]);
		drain();
	endtask

	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			begin
				int n = 0;
				while (n < 400) begin
					@(posedge clk);
					n++;
				end
				hold_rx = 1'b0;
			end
			begin
				send_message(3, 1'b1);
				send_message(2, 1'b1);
			end
		join
		drain();
	endtask

	task automatic test_random();
		int sent = 0;
		while (sent < 60) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
			if (sent > 45) idle_on = 1'b0;
			send_message(len, $urandom_range(0, 1));
			sent += len + 1;
			if ($urandom_range(0, 6) == 0) drain();
		end
		drain();
	endtask

	initial begin
		hasher_reset();
		for (int i = 0; i < 64; i++) blk_buf[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_edges();
		test_backpressure();
		test_random();
		repeat (300) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0) $display("[ OK ] regression clean");
		else begin
			if (digest_q.size() != 0)
				$display("%0t: %0d words never arrived", $time, digest_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
